[rtl/fjot_pkg.sv]
package fjot_pkg;

    // Parser phases; codes above PH_FINISHED are never reached
    typedef enum logic [3:0] {
        PH_OPEN        = 4'd0,
        PH_KEY_OR_END  = 4'd1,
        PH_IN_KEY      = 4'd2,
        PH_COLON       = 4'd3,
        PH_VALUE       = 4'd4,
        PH_IN_VALUE    = 4'd5,
        PH_AFTER_VALUE = 4'd6,
        PH_FINISHED    = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_ERROR  = 2'd2
    } status_t;

    localparam logic [1:0] KIND_SYNTAX = 2'd0;
    localparam logic [1:0] KIND_KEY    = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;

    localparam logic [1:0] CLOSED_NONE  = 2'd0;
    localparam logic [1:0] CLOSED_KEY   = 2'd1;
    localparam logic [1:0] CLOSED_VALUE = 2'd2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    // Outcome of one byte through the parser
    typedef struct packed {
        phase_t     phase;
        status_t    status;
        logic [1:0] kind;
        logic [1:0] closed;
    } step_res_t;

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

[rtl/fjot_step.sv]
module fjot_step
    import fjot_pkg::*;
(
    input  phase_t     phase,
    input  status_t    status,
    input  logic [7:0] c,
    input  logic       last,
    output step_res_t  res
);

    logic bad;

    always_comb
    begin
        bad        = 1'b0;
        res.phase  = phase;
        res.status = status;
        res.kind   = KIND_SYNTAX;
        res.closed = CLOSED_NONE;
        if (status == ST_BUSY)
        begin
            case (phase)
                PH_OPEN:
                begin
                    if (c == CH_LBRACE)
                        res.phase = PH_KEY_OR_END;
                    else if (!is_blank(c))
                        bad = 1'b1;
                end
                PH_KEY_OR_END:
                begin
                    if (c == CH_RBRACE)
                        res.status = ST_ACCEPT;
                    else if (c == CH_QUOTE)
                        res.phase = PH_IN_KEY;
                    else if (!is_blank(c))
                        bad = 1'b1;
                end
                PH_IN_KEY:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res.closed = CLOSED_KEY;
                        res.phase  = PH_COLON;
                    end
                    else
                        res.kind = KIND_KEY;
                end
                PH_COLON:
                begin
                    if (c == CH_COLON)
                        res.phase = PH_VALUE;
                    else if (!is_blank(c))
                        bad = 1'b1;
                end
                PH_VALUE:
                begin
                    if (c == CH_QUOTE)
                        res.phase = PH_IN_VALUE;
                    else if (!is_blank(c))
                        bad = 1'b1;
                end
                PH_IN_VALUE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res.closed = CLOSED_VALUE;
                        res.phase  = PH_AFTER_VALUE;
                    end
                    else
                        res.kind = KIND_VALUE;
                end
                PH_AFTER_VALUE:
                begin
                    if (c == CH_COMMA)
                        res.phase = PH_KEY_OR_END;
                    else if (c == CH_RBRACE)
                        res.status = ST_ACCEPT;
                    else if (c == CH_QUOTE)
                        res.phase = PH_IN_KEY;
                    else if (!is_blank(c))
                        bad = 1'b1;
                end
                default:
                    bad = 1'b1;
            endcase

            // A bad byte is tagged as syntax; an early end keeps its tag
            if (bad)
            begin
                res.status = ST_ERROR;
                res.kind   = KIND_SYNTAX;
                res.closed = CLOSED_NONE;
            end
            else if (res.status == ST_BUSY && last)
                res.status = ST_ERROR;

            if (res.status != ST_BUSY)
                res.phase = PH_FINISHED;
        end
    end

endmodule

[rtl/flat_json_object_tokenizer.sv]
// Pipeline: a byte passes through the input register, then the result
// register, before its result is offered.
// Throughput: one byte per cycle while the output is not stalled; the parser
// phase is updated in the same cycle that a byte leaves the input register.
// Reset (rst_n low, asynchronous): both stages empty, phase set to expect
// the opening brace, status back to in progress.
module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] char_out,
    output logic [1:0] char_kind,
    output logic [1:0] string_closed,
    output logic [1:0] parse_status
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    // Result stage
    logic       out_valid_reg;
    logic [7:0] char_reg;
    logic [1:0] kind_reg;
    logic [1:0] closed_reg;
    logic [1:0] status_out_reg;

    // Parser state
    phase_t     phase_reg;
    status_t    status_reg;

    step_res_t  res;
    logic       out_hold;
    logic       advance;

    // The result register is blocked only while it holds an untaken result;
    // the input register then holds too, and the stall reaches the source
    // only once the input register is also full.
    assign out_hold = out_valid_reg && out_stall;
    assign advance  = in_valid_reg && !out_hold;
    assign in_stall = in_valid_reg && out_hold;

    fjot_step u_step (
        .phase  (phase_reg),
        .status (status_reg),
        .c      (byte_reg),
        .last   (end_reg),
        .res    (res)
    );

    // Input register: load on every transfer, drain when the result side moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            end_reg  <= text_end;
        end
    end

    // Parser state advances exactly once per byte, as it enters the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            status_reg <= ST_BUSY;
        end
        else if (advance)
        begin
            phase_reg  <= res.phase;
            status_reg <= res.status;
        end
    end

    // Result register: hold while stalled, otherwise take whatever is in front
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_hold)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg       <= byte_reg;
            kind_reg       <= res.kind;
            closed_reg     <= res.closed;
            status_out_reg <= res.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign char_out      = char_reg;
    assign char_kind     = kind_reg;
    assign string_closed = closed_reg;
    assign parse_status  = status_out_reg;

endmodule

[rtl/fjot_checker.sv]
module fjot_checker
    import fjot_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] char_out,
    input logic [1:0] char_kind,
    input logic [1:0] string_closed,
    input logic [1:0] parse_status
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out)
            && $stable(parse_status))
        else $error("result changed while stalled");

    // A final status never changes again
    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status != ST_BUSY |=>
            !out_valid || parse_status == $past(parse_status))
        else $error("final status changed");

    // The accepting byte and everything after it are syntax
    a_accept_syntax: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status == ST_ACCEPT |->
            char_kind == KIND_SYNTAX && string_closed == CLOSED_NONE)
        else $error("content tag after acceptance");

    // Only a quote closes a string, and it is not content
    a_close_quote: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_closed != CLOSED_NONE |->
            char_out == CH_QUOTE && char_kind == KIND_SYNTAX)
        else $error("string closed by a non-quote");

endmodule

bind flat_json_object_tokenizer fjot_checker u_fjot_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .char_out      (char_out),
    .char_kind     (char_kind),
    .string_closed (string_closed),
    .parse_status  (parse_status)
);

[verif/testbench.sv]
module testbench;
    import fjot_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 4;
    localparam int BODY_BYTES   = 700;   // pairs are added until the text reaches this size
    localparam int TAIL_BYTES   = 30;    // bytes offered after the object has finished
    localparam int PACE_SPAN    = 60;    // bytes per pacing mode before moving to the next
    localparam int HOLD_CYCLES  = 48;    // length of the one long output hold-off
    localparam int MAX_GAP      = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer before giving up

    // One byte of object text as offered on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_item_t;

    // One predicted result token
    typedef struct {
        logic [7:0] ch;
        logic [1:0] kind;
        logic [1:0] closed;
        status_t    status;
    } token_t;

    // Pacing modes, visited in turn as the text is sent
    typedef enum int {
        PACE_FREE,
        PACE_HOLD,
        PACE_SEND,
        PACE_RECV,
        PACE_BOTH
    } pace_t;

    // How the object text is brought to an end
    typedef enum int {
        END_CLOSE,
        END_DOUBLE_COMMA,
        END_CUT_SHORT,
        END_BAD_BYTE
    } end_style_t;

    // Tracks the parser phase and outcome, and checks each token against
    // the oldest prediction.
    class token_scoreboard;
        phase_t  phase;
        status_t status;
        token_t  expected_q[$];
        int      mismatches;
        int      checked;

        function new();
            phase      = PH_OPEN;
            status     = ST_BUSY;
            mismatches = 0;
            checked    = 0;
        endfunction

        static function bit blank_char(logic [7:0] c);
            case (c)
                8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void note_text(logic [7:0] c, logic last);
            token_t t;
            bit     bad;
            t.ch     = c;
            t.kind   = KIND_SYNTAX;
            t.closed = CLOSED_NONE;
            bad      = 1'b0;
            if (status == ST_BUSY) begin
                case (phase)
                    PH_OPEN:
                        if (c == CH_LBRACE) phase = PH_KEY_OR_END;
                        else if (!blank_char(c)) bad = 1'b1;
                    PH_KEY_OR_END:
                        if (c == CH_RBRACE) status = ST_ACCEPT;
                        else if (c == CH_QUOTE) phase = PH_IN_KEY;
                        else if (!blank_char(c)) bad = 1'b1;
                    PH_IN_KEY:
                        if (c == CH_QUOTE) begin
                            t.closed = CLOSED_KEY;
                            phase    = PH_COLON;
                        end
                        else t.kind = KIND_KEY;
                    PH_COLON:
                        if (c == CH_COLON) phase = PH_VALUE;
                        else if (!blank_char(c)) bad = 1'b1;
                    PH_VALUE:
                        if (c == CH_QUOTE) phase = PH_IN_VALUE;
                        else if (!blank_char(c)) bad = 1'b1;
                    PH_IN_VALUE:
                        if (c == CH_QUOTE) begin
                            t.closed = CLOSED_VALUE;
                            phase    = PH_AFTER_VALUE;
                        end
                        else t.kind = KIND_VALUE;
                    PH_AFTER_VALUE:
                        if (c == CH_COMMA) phase = PH_KEY_OR_END;
                        else if (c == CH_RBRACE) status = ST_ACCEPT;
                        else if (c == CH_QUOTE) phase = PH_IN_KEY;
                        else if (!blank_char(c)) bad = 1'b1;
                    default:
                        bad = 1'b1;
                endcase
                // a string byte keeps its content tag even when the text ends on it
                if (bad) status = ST_ERROR;
                else if (status == ST_BUSY && last) status = ST_ERROR;
                if (status != ST_BUSY) phase = PH_FINISHED;
            end
            t.status = status;
            expected_q.push_back(t);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
        endtask

        task check_token(logic [7:0] ch, logic [1:0] kind, logic [1:0] closed,
                         logic [1:0] status_bits);
            token_t want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("token 0x%02h arrived with no byte outstanding", ch));
                return;
            end
            want = expected_q.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("token %0d char_out 0x%02h, want 0x%02h",
                                          checked, ch, want.ch));
            if (kind !== want.kind)
                report_mismatch($sformatf("token %0d (0x%02h) char_kind %0d, want %0d",
                                          checked, want.ch, kind, want.kind));
            if (closed !== want.closed)
                report_mismatch($sformatf("token %0d (0x%02h) string_closed %0d, want %0d",
                                          checked, want.ch, closed, want.closed));
            if (status_bits !== want.status)
                report_mismatch($sformatf("token %0d (0x%02h) parse_status %0d, want %0d",
                                          checked, want.ch, status_bits, want.status));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       text_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] char_out;
    logic [1:0] char_kind;
    logic [1:0] string_closed;
    logic [1:0] parse_status;

    token_scoreboard sb = new();

    text_item_t text_q[$];
    pace_t      pace = PACE_FREE;
    int         send_pct = 0;
    int         recv_pct = 0;
    int         pair_count = 0;
    int         quiet_cycles = 0;
    end_style_t end_style;

    const logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    flat_json_object_tokenizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .text_end      (text_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_out      (char_out),
        .char_kind     (char_kind),
        .string_closed (string_closed),
        .parse_status  (parse_status)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Text building. The whole object is built up front as one stream:
    // the parser only ever finishes once per reset, so the run is one long
    // well-formed object with random content, closed by a randomly chosen
    // ending, followed by bytes the block should merely echo.
    // ------------------------------------------------------------------

    function automatic void put(logic [7:0] c, logic last = 1'b0);
        text_item_t t;
        t.ch   = c;
        t.last = last;
        text_q.push_back(t);
    endfunction

    // Add a short run of whitespace between tokens, most often none at all
    function automatic void put_blanks();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        repeat (n) put(BLANKS[$urandom_range(5)]);
    endfunction

    // String content: any byte but a quote, sometimes held to printable text
    function automatic void put_string();
        logic [7:0] c;
        bit         plain;
        int         len;
        plain = $urandom_range(1);
        len   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        repeat (len) begin
            do
                c = plain ? 8'($urandom_range(8'h7E, 8'h20)) : 8'($urandom_range(255));
            while (c == CH_QUOTE);
            put(c);
        end
    endfunction

    function automatic void put_pair();
        put(CH_QUOTE);
        put_string();
        put(CH_QUOTE);
        put_blanks();
        put(CH_COLON);
        put_blanks();
        put(CH_QUOTE);
        put_string();
        put(CH_QUOTE);
        pair_count++;
    endfunction

    // A byte that is neither whitespace nor any of the three given characters
    function automatic logic [7:0] stray_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] r;
        do
            r = 8'($urandom_range(255));
        while (r == a || r == b || r == c || token_scoreboard::blank_char(r));
        return r;
    endfunction

    function automatic void build_text();
        int     cut;
        int     start;
        phase_t bad_at;
        logic [7:0] lead [] = '{8'h20, 8'h09, 8'h0C, CH_LBRACE,
                                // empty key and empty value, no whitespace at all
                                CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_QUOTE,
                                // key straight after a value, holding extreme and syntax bytes
                                CH_QUOTE, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_LBRACE, CH_RBRACE,
                                CH_COMMA, CH_COLON, 8'h20, CH_QUOTE,
                                8'h0B, CH_COLON, 8'h0A, CH_QUOTE, 8'h0D, CH_QUOTE, 8'h0D,
                                CH_COMMA};
        foreach (lead[i]) put(lead[i]);

        // body: pairs with random content, optional commas and whitespace
        while (text_q.size() < BODY_BYTES) begin
            put_blanks();
            put_pair();
            put_blanks();
            if ($urandom_range(1)) put(CH_COMMA);
        end

        end_style = end_style_t'($urandom_range(END_BAD_BYTE));
        case (end_style)
            END_CLOSE: begin
                // a trailing comma is allowed; the final byte may also carry text_end
                if ($urandom_range(1)) put(CH_COMMA);
                put_blanks();
                put(CH_RBRACE, 1'($urandom_range(1)));
            end
            END_DOUBLE_COMMA: begin
                put(CH_COMMA);
                put_blanks();
                put(CH_COMMA);
            end
            END_CUT_SHORT: begin
                // end the text somewhere inside a fresh pair
                start = text_q.size();
                put_pair();
                cut = $urandom_range(text_q.size() - 1, start);
                text_q = text_q[0:cut];
                text_q[cut].last = 1'b1;
            end
            END_BAD_BYTE: begin
                case ($urandom_range(2))
                    0:       bad_at = PH_COLON;
                    1:       bad_at = PH_VALUE;
                    default: bad_at = PH_AFTER_VALUE;
                endcase
                if (bad_at != PH_AFTER_VALUE) begin
                    put(CH_QUOTE);
                    put_string();
                    put(CH_QUOTE);
                    put_blanks();
                end
                case (bad_at)
                    PH_COLON:
                        put(stray_byte(CH_COLON, CH_COLON, CH_COLON));
                    PH_VALUE: begin
                        put(CH_COLON);
                        put_blanks();
                        put(stray_byte(CH_QUOTE, CH_QUOTE, CH_QUOTE));
                    end
                    default:
                        put(stray_byte(CH_QUOTE, CH_COMMA, CH_RBRACE));
                endcase
            end
        endcase

        // after the finish everything is echoed with the held status
        repeat (TAIL_BYTES) put(8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, with random idle cycles first.
    // ------------------------------------------------------------------

    task automatic send_text(text_item_t t);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= t.ch;
        text_end  <= t.last;
        // hold the payload until the block takes it
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    function automatic void set_pace(pace_t p);
        pace = p;
        case (p)
            PACE_SEND: begin send_pct = 82; recv_pct = 0;  end
            PACE_RECV: begin send_pct = 0;  recv_pct = 82; end
            PACE_BOTH: begin send_pct = 14; recv_pct = 14; end
            default:   begin send_pct = 0;  recv_pct = 0;  end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off the first time the
    // hold mode comes round, so the two pipeline stages fill and the block
    // pushes back on its input.
    // ------------------------------------------------------------------

    initial begin : receiver
        int held;
        held      = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (pace == PACE_HOLD && held < HOLD_CYCLES) begin
                out_stall <= 1'b1;
                held++;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog: note every input transfer, check every output
    // transfer, and give up after a long spell with no transfer at all.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_text(text_byte, text_end);
            if (out_valid && !out_stall)
                sb.check_token(char_out, char_kind, string_closed, parse_status);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                     $realtime, QUIET_LIMIT, sb.expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        text_byte = 8'h00;
        text_end  = 1'b0;
        build_text();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk through the pacing modes in turn, PACE_SPAN bytes each
        for (int i = 0; i < text_q.size(); i++) begin
            set_pace(pace_t'((i / PACE_SPAN) % (PACE_BOTH + 1)));
            send_text(text_q[i]);
        end
        in_valid <= 1'b0;

        // drain, then allow a few more cycles for any stray token
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes (%0d key/value pairs) and checked %0d tokens",
                 text_q.size(), pair_count, sb.checked);
        $display("Ending %s gave final status %s; %0d mismatches",
                 end_style.name(), sb.status.name(), sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
